[rtl/sha1sh_pkg.sv]
package sha1sh_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 5;
    localparam int MSG_BITS     = 61;
    localparam int ROUND_BITS   = 5;

    localparam logic [ROUND_BITS-1:0] ROUNDS_LAST = 5'd19;
    localparam logic [2:0]            DIGEST_LAST = 3'd4;
    localparam logic [2:0]            WORD_BYTES  = 3'd4;
    localparam logic [7:0]            PAD_BYTE    = 8'h80;
    localparam logic [5:0]            POS_LEN     = 6'd56;

    localparam logic [31:0] SHA1_IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    // round groups of twenty
    localparam logic [1:0] STG_CH   = 2'd0;
    localparam logic [1:0] STG_PAR1 = 2'd1;
    localparam logic [1:0] STG_MAJ  = 2'd2;
    localparam logic [1:0] STG_PAR2 = 2'd3;

    // byte source for the merge unit
    localparam logic [1:0] SRC_IN   = 2'd0;
    localparam logic [1:0] SRC_HOLD = 2'd1;
    localparam logic [1:0] SRC_PAD  = 2'd2;
    localparam logic [1:0] SRC_ZERO = 2'd3;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        final_word;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } t_out;

    typedef struct packed {
        logic       merge;
        logic [1:0] src;
        logic       len_wr;
        logic       round;
        logic [1:0] stage;
        logic       add;
        logic       dig_load;
    } t_cmd;

    typedef struct packed {
        logic wrap;
        logic rem_zero;
        logic pos56;
        logic out_busy;
    } t_status;

endpackage

[rtl/sha1sh_ctrl.sv]
module sha1sh_ctrl
    import sha1sh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_final_word,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MERGE = 3'd1;
    localparam logic [2:0] S_PAD   = 3'd2;
    localparam logic [2:0] S_ZFILL = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_DIG   = 3'd7;

    logic [2:0]            r_state, n_state;
    logic                  r_final, n_final;
    logic                  r_padded, n_padded;
    logic                  r_len_done, n_len_done;
    logic [ROUND_BITS-1:0] r_round, n_round;
    logic [1:0]            r_stage, n_stage;

    function automatic logic [2:0] f_next(input t_status st, input logic fin,
                                          input logic pad, input logic lend);
        logic [2:0] nxt;
        if (st.wrap) begin
            nxt = S_ROUND;
        end else if (!st.rem_zero) begin
            nxt = S_MERGE;
        end else if (!fin) begin
            nxt = S_IDLE;
        end else if (!pad) begin
            nxt = S_PAD;
        end else if (lend) begin
            nxt = S_DIG;
        end else if (st.pos56) begin
            nxt = S_LEN;
        end else begin
            nxt = S_ZFILL;
        end
        return nxt;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_final    = r_final;
        n_padded   = r_padded;
        n_len_done = r_len_done;
        n_round    = r_round;
        n_stage    = r_stage;
        o_cmd          = '0;
        o_cmd.stage    = r_stage;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.merge = 1'b1;
                    o_cmd.src   = SRC_IN;
                    n_final     = i_final_word;
                    n_state     = f_next(i_status, n_final, n_padded, n_len_done);
                end
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                o_cmd.src   = SRC_HOLD;
                n_state     = f_next(i_status, n_final, n_padded, n_len_done);
            end
            S_PAD: begin
                o_cmd.merge = 1'b1;
                o_cmd.src   = SRC_PAD;
                n_padded    = 1'b1;
                n_state     = f_next(i_status, n_final, n_padded, n_len_done);
            end
            S_ZFILL: begin
                o_cmd.merge = 1'b1;
                o_cmd.src   = SRC_ZERO;
                n_state     = f_next(i_status, n_final, n_padded, n_len_done);
            end
            S_LEN: begin
                o_cmd.len_wr = 1'b1;
                n_len_done   = 1'b1;
                n_state      = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_round == ROUNDS_LAST) begin
                    n_round = '0;
                    n_stage = r_stage + 2'd1;
                    if (r_stage == STG_PAR2) begin
                        n_state = S_ADD;
                    end
                end else begin
                    n_round = r_round + 5'd1;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = f_next(i_status, n_final, n_padded, n_len_done);
            end
            S_DIG: begin
                // hold until the previous digest has drained
                if (!i_status.out_busy) begin
                    o_cmd.dig_load = 1'b1;
                    n_final        = 1'b0;
                    n_padded       = 1'b0;
                    n_len_done     = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_final    <= 1'b0;
            r_padded   <= 1'b0;
            r_len_done <= 1'b0;
            r_round    <= '0;
            r_stage    <= STG_CH;
        end else begin
            r_state    <= n_state;
            r_final    <= n_final;
            r_padded   <= n_padded;
            r_len_done <= n_len_done;
            r_round    <= n_round;
            r_stage    <= n_stage;
        end
    end

endmodule

[rtl/sha1sh_dpath.sv]
module sha1sh_dpath
    import sha1sh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in_data,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out_data
);

    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;

    logic [31:0]         r_sched [BLOCK_WORDS];
    logic [31:0]         r_chain [DIGEST_WORDS];
    logic [31:0]         r_dig   [DIGEST_WORDS];
    logic [31:0]         r_a, r_b, r_c, r_d, r_e;
    logic [31:0]         r_hold, n_hold;
    logic [2:0]          r_rem, n_rem;
    logic [5:0]          r_pos, n_pos;
    logic [MSG_BITS-1:0] r_msg;
    logic [2:0]          r_out_left;
    logic [2:0]          r_out_idx;

    logic [31:0] w_src;
    logic [2:0]  w_rem_src;
    logic [1:0]  w_off;
    logic [2:0]  w_room;
    logic [2:0]  w_n;
    logic [6:0]  w_pos_sum;
    logic [31:0] w_aligned;
    logic [3:0]  w_lane_en;
    logic [3:0]  w_idx;
    logic [31:0] w_f, w_k, w_tmp, w_new_w;
    logic        w_out_take;

    // merge unit: place as many bytes as fit in the current buffer word
    always_comb begin
        case (i_cmd.src)
            SRC_IN: begin
                w_src     = i_in_data.data_word;
                w_rem_src = (i_in_data.byte_count > WORD_BYTES) ? WORD_BYTES
                                                                : i_in_data.byte_count;
            end
            SRC_HOLD: begin
                w_src     = r_hold;
                w_rem_src = r_rem;
            end
            SRC_PAD: begin
                w_src     = {PAD_BYTE, 24'h000000};
                w_rem_src = WORD_BYTES;
            end
            default: begin
                w_src     = '0;
                w_rem_src = WORD_BYTES;
            end
        endcase
    end

    assign w_off     = r_pos[1:0];
    assign w_idx     = r_pos[5:2];
    assign w_room    = WORD_BYTES - {1'b0, w_off};
    assign w_n       = !i_cmd.merge ? 3'd0 : ((w_rem_src < w_room) ? w_rem_src : w_room);
    assign w_pos_sum = {1'b0, r_pos} + {4'b0000, w_n};
    assign w_aligned = w_src >> {w_off, 3'b000};

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_lane_en[l] = ({1'b0, l[1:0]} >= {1'b0, w_off}) &&
                           ({1'b0, l[1:0]} < ({1'b0, w_off} + w_n));
        end
    end

    always_comb begin
        n_hold = r_hold;
        n_rem  = r_rem;
        n_pos  = r_pos;
        if (i_cmd.merge) begin
            n_hold = w_src << {w_n, 3'b000};
            n_rem  = (i_cmd.src == SRC_IN || i_cmd.src == SRC_HOLD) ? (w_rem_src - w_n)
                                                                   : 3'd0;
            n_pos  = w_pos_sum[5:0];
        end else if (i_cmd.len_wr) begin
            n_pos = '0;
        end
    end

    assign o_status.wrap     = w_pos_sum[6];
    assign o_status.rem_zero = (n_rem == 3'd0);
    assign o_status.pos56    = (n_pos == POS_LEN);
    assign o_status.out_busy = (r_out_left != 3'd0);

    // round function
    always_comb begin
        case (i_cmd.stage)
            STG_CH: begin
                w_f = r_d ^ (r_b & (r_c ^ r_d));
                w_k = K_CH;
            end
            STG_PAR1: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = K_PAR1;
            end
            STG_MAJ: begin
                w_f = (r_b & r_c) | (r_d & (r_b | r_c));
                w_k = K_MAJ;
            end
            default: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = K_PAR2;
            end
        endcase
    end

    assign w_tmp   = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_sched[0];
    assign w_new_w = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];

    // schedule window: entry 0 always holds the word of the current round
    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                r_sched[j] <= r_sched[j+1];
            end
            r_sched[BLOCK_WORDS-1] <= {w_new_w[30:0], w_new_w[31]};
        end else if (i_cmd.len_wr) begin
            r_sched[LEN_HI_IDX] <= r_msg[MSG_BITS-1:29];
            r_sched[LEN_LO_IDX] <= {r_msg[28:0], 3'b000};
        end else if (i_cmd.merge) begin
            for (int l = 0; l < 4; l++) begin
                if (w_lane_en[l]) begin
                    r_sched[w_idx][31-8*l -: 8] <= w_aligned[31-8*l -: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.merge) begin
            r_hold <= n_hold;
        end
    end

    assign w_out_take = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.dig_load) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_dig[i] <= r_chain[i];
            end
        end else if (w_out_take) begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_chain[i] <= SHA1_IV[i];
            end
            r_a        <= SHA1_IV[0];
            r_b        <= SHA1_IV[1];
            r_c        <= SHA1_IV[2];
            r_d        <= SHA1_IV[3];
            r_e        <= SHA1_IV[4];
            r_rem      <= '0;
            r_pos      <= '0;
            r_msg      <= '0;
            r_out_left <= '0;
            r_out_idx  <= '0;
        end else begin
            r_rem <= n_rem;
            r_pos <= n_pos;
            if (i_cmd.merge && i_cmd.src == SRC_IN) begin
                r_msg <= r_msg + {{(MSG_BITS-3){1'b0}}, w_rem_src};
            end
            if (i_cmd.round) begin
                r_a <= w_tmp;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
            end else if (i_cmd.add) begin
                // keep the working registers equal to the chain between blocks
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
                r_a        <= r_chain[0] + r_a;
                r_b        <= r_chain[1] + r_b;
                r_c        <= r_chain[2] + r_c;
                r_d        <= r_chain[3] + r_d;
                r_e        <= r_chain[4] + r_e;
            end else if (i_cmd.dig_load) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_chain[i] <= SHA1_IV[i];
                end
                r_a   <= SHA1_IV[0];
                r_b   <= SHA1_IV[1];
                r_c   <= SHA1_IV[2];
                r_d   <= SHA1_IV[3];
                r_e   <= SHA1_IV[4];
                r_msg <= '0;
            end
            if (i_cmd.dig_load) begin
                r_out_left <= 3'(DIGEST_WORDS);
                r_out_idx  <= '0;
            end else if (w_out_take) begin
                r_out_left <= r_out_left - 3'd1;
                r_out_idx  <= r_out_idx + 3'd1;
            end
        end
    end

    assign o_out_valid                = (r_out_left != 3'd0);
    assign o_out_data.digest_word    = r_dig[0];
    assign o_out_data.word_index     = r_out_idx;
    assign o_out_data.last_of_digest = (r_out_idx == DIGEST_LAST);

endmodule

[rtl/sha1_stream_hasher_unit.sv]
// Full input word: a second merge step when it straddles a buffer word; the word that fills a
// 64-byte block then starts 80 rounds on one round unit, followed by the chain update.
// Input is not accepted while a block is being padded or compressed.
// Final word: pad and zero-fill steps, the length write, and one or two compressions;
// once the previous digest has left, the output loads, then one word per cycle while ready.
// Reset: synchronous, active low; chain returns to the initial vector, counts to zero.
module sha1_stream_hasher_unit
    import sha1sh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd    w_cmd;
    t_status w_status;

    sha1sh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_word (i_in_data.final_word),
        .o_in_ready   (o_in_ready),
        .o_cmd        (w_cmd),
        .i_status     (w_status)
    );

    sha1sh_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_dig_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.dig_load |-> !o_out_valid)
        else $error("digest loaded over a pending request");

    a_digest_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_of_digest) |=> o_out_valid)
        else $error("digest stream broke before its last word");

    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.final_word) |=> !o_in_ready)
        else $error("input ready right after a final word");

    a_round_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.round || w_cmd.add) |-> !o_in_ready)
        else $error("input ready during compression");
`endif

endmodule

[test/sha1_stream_hasher_unit_tb.sv]
`timescale 1ns / 100ps

module sha1_stream_hasher_unit_tb;
    import sha1sh_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    sha1_stream_hasher_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // message words waiting to go out, and whether each one waits for an empty digest queue
    t_in  pend_q[$];
    bit   hold_q[$];
    bit   hold_next;
    int   stim_items;

    // digest words still owed by the block
    t_out digest_q[$];
    int   mismatch_cnt;
    int   cycle_cnt;

    bit   in_taken;
    bit   out_taken;
    bit   tx_quiet;
    bit   rx_quiet;
    int   tx_gap;
    int   rx_stall;

    // hash state of the predictor
    logic [31:0] chain_h [DIGEST_WORDS];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  blk_pos;
    logic [60:0] msg_len;

    always #5 i_clk = ~i_clk;

    task automatic sha1_fold();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, x, tmp;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                x = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
                wt = {x[30:0], x[31]};
                w[t & 15] = wt;
            end
            if (t < 20) begin
                f = d ^ (b & (c ^ d));
                k = K_CH;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end else if (t < 60) begin
                f = (b & c) | (d & (b | c));
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + wt;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    task automatic sha1_put_byte(input logic [7:0] val);
        blk_bytes[blk_pos] = val;
        blk_pos = blk_pos + 6'd1;
        if (blk_pos == 6'd0) begin
            sha1_fold();
        end
    endtask

    // absorb one accepted request; a final word pads the message and owes five digest words
    task automatic sha1_absorb(input t_in req);
        int          cnt;
        logic [63:0] bit_len;
        t_out        res;
        cnt = (req.byte_count > WORD_BYTES) ? 4 : int'(req.byte_count);
        for (int i = 0; i < cnt; i++) begin
            sha1_put_byte(req.data_word[31-8*i -: 8]);
        end
        msg_len = msg_len + 61'(cnt);
        if (req.final_word) begin
            sha1_put_byte(PAD_BYTE);
            while (blk_pos != POS_LEN) begin
                sha1_put_byte(8'h00);
            end
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++) begin
                sha1_put_byte(bit_len[63-8*i -: 8]);
            end
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                res.digest_word    = chain_h[i];
                res.word_index     = 3'(i);
                res.last_of_digest = (3'(i) == DIGEST_LAST);
                digest_q.push_back(res);
            end
            chain_h = SHA1_IV;
            msg_len = '0;
        end
    endtask

    task automatic queue_req(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
        t_in r;
        r.data_word  = data;
        r.byte_count = cnt;
        r.final_word = fin;
        pend_q.push_back(r);
        hold_q.push_back(hold_next);
        hold_next = 1'b0;
        if (cnt != 3'd0 || fin) begin
            stim_items++;
        end
    endtask

    // random bytes; a noisy message also carries empty words, short words and oversized counts
    task automatic queue_message(input int nbytes, input bit noisy);
        int         left, take, sel;
        logic [2:0] cnt;
        logic       fin;
        left = nbytes;
        fin  = 1'b0;
        while (left > 0) begin
            take = (left >= 4) ? 4 : left;
            cnt  = 3'(take);
            sel  = noisy ? $urandom_range(0, 9) : 9;
            if (sel == 0) begin
                queue_req($urandom, 3'd0, 1'b0);
            end else if (sel == 1) begin
                take = $urandom_range(1, take);
                cnt  = 3'(take);
            end else if (sel == 2 && take == 4) begin
                cnt = 3'($urandom_range(5, 7));
            end
            left -= take;
            fin = (left == 0) && ($urandom_range(0, 3) != 0);
            queue_req($urandom, cnt, fin);
        end
        if (!fin) begin
            queue_req($urandom, 3'd0, 1'b1);
        end
    endtask

    // sample both handshakes, predict and check
    always @(posedge i_clk) begin : mon
        t_out want;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (in_taken) begin
            sha1_absorb(i_in_data);
        end
        if (out_taken) begin
            if (digest_q.size() == 0) begin
                $display("%0t: digest word with none expected: got %h idx %0d last %b", $time,
                         o_out_data.digest_word, o_out_data.word_index,
                         o_out_data.last_of_digest);
                mismatch_cnt++;
            end else begin
                want = digest_q.pop_front();
                if (o_out_data.digest_word !== want.digest_word) begin
                    $display("%0t: digest_word expected %h got %h", $time,
                             want.digest_word, o_out_data.digest_word);
                    mismatch_cnt++;
                end
                if (o_out_data.word_index !== want.word_index) begin
                    $display("%0t: word_index expected %0d got %0d", $time,
                             want.word_index, o_out_data.word_index);
                    mismatch_cnt++;
                end
                if (o_out_data.last_of_digest !== want.last_of_digest) begin
                    $display("%0t: last_of_digest expected %b got %b", $time,
                             want.last_of_digest, o_out_data.last_of_digest);
                    mismatch_cnt++;
                end
            end
        end
        if (i_rst_n) begin
            cycle_cnt++;
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d digest words outstanding", $time, digest_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (in_taken || !i_in_valid)) begin
            if (tx_gap != 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pend_q.size() != 0 && !(hold_q[0] && digest_q.size() != 0)) begin
                i_in_data  <= pend_q.pop_front();
                void'(hold_q.pop_front());
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 19) == 0) begin
                    tx_quiet = !tx_quiet;
                end
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 6);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // digest receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                if ($urandom_range(0, 15) == 0) begin
                    rx_quiet = !rx_quiet;
                end
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 6);
            end
            if (rx_stall != 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stim
        int nbytes;
        int sel;
        bit noisy;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        hold_next    = 1'b0;
        stim_items   = 0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        in_taken     = 1'b0;
        out_taken    = 1'b0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        tx_gap       = 0;
        rx_stall     = 0;
        chain_h      = SHA1_IV;
        blk_pos      = '0;
        msg_len      = '0;

        // empty message, then "abc" with junk below the valid bytes
        queue_req(32'h0000_0000, 3'd0, 1'b1);
        queue_req(32'h6162_63FF, 3'd3, 1'b1);
        // all-ones word alone, then zeros followed by a short all-ones tail
        queue_req(32'hFFFF_FFFF, 3'd4, 1'b1);
        hold_next = 1'b1;
        queue_req(32'h0000_0000, 3'd4, 1'b0);
        queue_req(32'hFFFF_FFFF, 3'd2, 1'b1);
        // oversized counts behave as four
        queue_req(32'hA5A5_5A5A, 3'd5, 1'b0);
        queue_req(32'h0123_4567, 3'd6, 1'b0);
        queue_req(32'h89AB_CDEF, 3'd7, 1'b0);
        queue_req(32'hDEAD_BEEF, 3'd1, 1'b1);
        // short words in the middle of a message
        queue_req(32'h1122_3344, 3'd1, 1'b0);
        queue_req(32'h5566_7788, 3'd3, 1'b0);
        queue_req(32'h99AA_BBCC, 3'd2, 1'b0);
        queue_req(32'hDDEE_FF00, 3'd4, 1'b1);
        // empty non-final word is dropped, then an empty message
        queue_req(32'hFFFF_FFFF, 3'd0, 1'b0);
        queue_req(32'hFFFF_FFFF, 3'd0, 1'b1);

        // random messages; a few sit on the padding and block boundaries
        hold_next  = 1'b1;
        while (stim_items < 110) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                case ($urandom_range(0, 6))
                    0: nbytes = 55;
                    1: nbytes = 56;
                    2: nbytes = 63;
                    3: nbytes = 64;
                    4: nbytes = 119;
                    5: nbytes = 120;
                    default: nbytes = 128;
                endcase
            end else if (sel < 8) begin
                nbytes = $urandom_range(0, 40);
            end else begin
                nbytes = $urandom_range(41, 140);
            end
            noisy = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) begin
                hold_next = 1'b1;
            end
            queue_message(nbytes, noisy);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sha1_stream_hasher_unit.f]
rtl/sha1sh_pkg.sv
rtl/sha1sh_ctrl.sv
rtl/sha1sh_dpath.sv
rtl/sha1_stream_hasher_unit.sv
test/sha1_stream_hasher_unit_tb.sv
